>>> hw/rtl/dbfc_pkg.sv
package dbfc_pkg;

  // build-time sizing
  localparam int MAX_BLOCKS_ACROSS = 32;
  localparam int PIXEL_CHANNELS    = 3;
  localparam int QUEUE_DEPTH       = 2;

  // field widths
  localparam int PIXEL_W      = 24;
  localparam int BLOCK_COL_W  = 5;
  localparam int BLOCK_ROW_W  = 6;
  localparam int BW_REG_W     = 9;
  localparam int BH_REG_W     = 10;
  localparam int BA_REG_W     = 6;
  localparam int BD_REG_W     = 7;
  localparam int PIX_CNT_W    = 8;
  localparam int ROW_CNT_W    = 9;
  localparam int CFG_INDEX_W  = 4;
  localparam int CFG_DATA_W   = 16;

  // register limits
  localparam logic [BW_REG_W-1:0] BW_MAX = 9'd256;
  localparam logic [BH_REG_W-1:0] BH_MAX = 10'd512;
  localparam logic [BD_REG_W-1:0] BD_MAX = 7'd64;

  // register reset values
  localparam logic [BW_REG_W-1:0] BW_RESET = 9'd120;
  localparam logic [BH_REG_W-1:0] BH_RESET = 10'd300;
  localparam logic [BA_REG_W-1:0] BA_RESET = 6'd32;
  localparam logic [BD_REG_W-1:0] BD_RESET = 7'd8;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BLK_WIDTH     = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLK_HEIGHT    = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCKS_ACROSS = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCKS_DOWN   = 4'd3;

  // bytes of a pixel that take part in the compare
  function automatic logic [PIXEL_W-1:0] channel_mask(input int n);
    logic [PIXEL_W-1:0] m;
    m = '0;
    for (int i = 0; i < PIXEL_W / 8; i++) begin
      if (i < n) begin
        m[i*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/dbfc_if.sv
// pixel pair channel
interface dbfc_in_if;
  logic                         valid;
  logic                         ready;
  logic [dbfc_pkg::PIXEL_W-1:0] pixel_first;
  logic [dbfc_pkg::PIXEL_W-1:0] pixel_second;

  modport source (output valid, output pixel_first, output pixel_second, input ready);
  modport sink   (input valid, input pixel_first, input pixel_second, output ready);
endinterface

// block result channel
interface dbfc_out_if;
  logic                             valid;
  logic                             ready;
  logic [dbfc_pkg::BLOCK_COL_W-1:0] block_column;
  logic [dbfc_pkg::BLOCK_ROW_W-1:0] block_row;
  logic                             changed;
  logic                             frame_any_change;
  logic                             last_of_row;
  logic                             last_of_frame;

  modport source (output valid, output block_column, output block_row, output changed,
                  output frame_any_change, output last_of_row, output last_of_frame,
                  input ready);
  modport sink   (input valid, input block_column, input block_row, input changed,
                  input frame_any_change, input last_of_row, input last_of_frame,
                  output ready);
endinterface

// register write channel
interface dbfc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dbfc_pkg::CFG_INDEX_W-1:0] index;
  logic [dbfc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/dbfc_queue.sv
module dbfc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = dbfc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hw/rtl/dbfc_front.sv
module dbfc_front #(
  parameter int MAX_BLOCKS_ACROSS = dbfc_pkg::MAX_BLOCKS_ACROSS,
  localparam int COL_W   = $clog2(MAX_BLOCKS_ACROSS + 1),
  localparam int ENTRY_W = MAX_BLOCKS_ACROSS + dbfc_pkg::BLOCK_ROW_W + COL_W + 1
) (
  input  logic               clk,
  input  logic               rst_n,
  dbfc_in_if.sink            in_ch,
  dbfc_cfg_if.sink           cfg_ch,
  output logic               push_valid,
  input  logic               push_ready,
  output logic [ENTRY_W-1:0] push_data
);

  localparam int BW_W  = dbfc_pkg::BW_REG_W;
  localparam int BH_W  = dbfc_pkg::BH_REG_W;
  localparam int BA_W  = dbfc_pkg::BA_REG_W;
  localparam int BD_W  = dbfc_pkg::BD_REG_W;
  localparam int ROW_W = dbfc_pkg::BLOCK_ROW_W;

  // configuration registers
  logic [BW_W-1:0] width_px_r;
  logic [BH_W-1:0] height_rows_r;
  logic [BA_W-1:0] blocks_across_r;
  logic [BD_W-1:0] blocks_down_r;

  // position and flag state
  logic [dbfc_pkg::PIX_CNT_W-1:0] pix_r, pix_nxt;
  logic [COL_W-1:0]               col_r, col_nxt;
  logic [dbfc_pkg::ROW_CNT_W-1:0] row_r, row_nxt;
  logic [ROW_W-1:0]               brow_r, brow_nxt;
  logic [MAX_BLOCKS_ACROSS-1:0]   flags_r, flags_nxt;

  logic [BW_W-1:0]              bw;
  logic [BH_W-1:0]              bh;
  logic [BD_W-1:0]              bd;
  logic [31:0]                  ba_i;
  logic [COL_W-1:0]             ba;
  logic [COL_W-1:0]             col_c;
  logic                         hit;
  logic [MAX_BLOCKS_ACROSS-1:0] flag_set, flags_all;
  logic                         pix_wrap, col_wrap, row_wrap, row_end, frame_end;
  logic                         accept;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = push_ready;
  assign accept       = in_ch.valid && in_ch.ready;

  // register writes, value masked to the register width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_px_r      <= dbfc_pkg::BW_RESET;
      height_rows_r   <= dbfc_pkg::BH_RESET;
      blocks_across_r <= dbfc_pkg::BA_RESET;
      blocks_down_r   <= dbfc_pkg::BD_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        dbfc_pkg::REG_BLK_WIDTH:     width_px_r      <= cfg_ch.data[BW_W-1:0];
        dbfc_pkg::REG_BLK_HEIGHT:    height_rows_r   <= cfg_ch.data[BH_W-1:0];
        dbfc_pkg::REG_BLOCKS_ACROSS: blocks_across_r <= cfg_ch.data[BA_W-1:0];
        dbfc_pkg::REG_BLOCKS_DOWN:   blocks_down_r   <= cfg_ch.data[BD_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers into range: zero acts as one
  always_comb begin
    bw = (width_px_r == '0) ? BW_W'(1) :
         (width_px_r > dbfc_pkg::BW_MAX) ? dbfc_pkg::BW_MAX : width_px_r;
    bh = (height_rows_r == '0) ? BH_W'(1) :
         (height_rows_r > dbfc_pkg::BH_MAX) ? dbfc_pkg::BH_MAX : height_rows_r;
    bd = (blocks_down_r == '0) ? BD_W'(1) :
         (blocks_down_r > dbfc_pkg::BD_MAX) ? dbfc_pkg::BD_MAX : blocks_down_r;
    ba_i = (blocks_across_r == '0) ? 32'd1 :
           (32'(blocks_across_r) > 32'(MAX_BLOCKS_ACROSS)) ? 32'(MAX_BLOCKS_ACROSS) :
           32'(blocks_across_r);
    ba = COL_W'(ba_i);
  end

  // compare the pixel pair and mark its block column
  always_comb begin
    hit       = |((in_ch.pixel_first ^ in_ch.pixel_second) &
                  dbfc_pkg::channel_mask(dbfc_pkg::PIXEL_CHANNELS));
    col_c     = (col_r >= ba) ? ba - COL_W'(1) : col_r;
    flag_set  = hit ? (MAX_BLOCKS_ACROSS'(1) << col_c) : '0;
    flags_all = flags_r | flag_set;
  end

  // position walk through the block grid
  always_comb begin
    pix_wrap  = !(({1'b0, pix_r} + BW_W'(1)) < bw);
    col_wrap  = !(({1'b0, col_r} + (COL_W+1)'(1)) < {1'b0, ba});
    row_wrap  = !(({1'b0, row_r} + BH_W'(1)) < bh);
    row_end   = pix_wrap && col_wrap && row_wrap;
    frame_end = (({1'b0, brow_r} + BD_W'(1)) >= bd);

    pix_nxt   = pix_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    brow_nxt  = brow_r;
    flags_nxt = flags_r;
    if (accept) begin
      flags_nxt = flags_all;
      pix_nxt   = pix_wrap ? '0 : pix_r + dbfc_pkg::PIX_CNT_W'(1);
      if (pix_wrap) begin
        col_nxt = col_wrap ? '0 : col_r + COL_W'(1);
        if (col_wrap) begin
          row_nxt = row_wrap ? '0 : row_r + dbfc_pkg::ROW_CNT_W'(1);
        end
      end
      if (row_end) begin
        flags_nxt = '0;
        brow_nxt  = frame_end ? '0 : brow_r + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
      brow_r  <= '0;
      flags_r <= '0;
    end else begin
      pix_r   <= pix_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      brow_r  <= brow_nxt;
      flags_r <= flags_nxt;
    end
  end

  // hand a finished block row to the back end
  assign push_valid = accept && row_end;
  assign push_data  = {flags_all, brow_r, ba, frame_end};

endmodule

>>> hw/rtl/dbfc_back.sv
module dbfc_back #(
  parameter int MAX_BLOCKS_ACROSS = dbfc_pkg::MAX_BLOCKS_ACROSS,
  localparam int COL_W   = $clog2(MAX_BLOCKS_ACROSS + 1),
  localparam int ENTRY_W = MAX_BLOCKS_ACROSS + dbfc_pkg::BLOCK_ROW_W + COL_W + 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  logic [ENTRY_W-1:0] q_data,
  output logic               q_pop,
  dbfc_out_if.source         out_ch
);

  localparam int ROW_W = dbfc_pkg::BLOCK_ROW_W;

  // row being reported
  logic                         busy_r, busy_nxt;
  logic [MAX_BLOCKS_ACROSS-1:0] vec_r, vec_nxt;
  logic [COL_W-1:0]             k_r, k_nxt;
  logic [ROW_W-1:0]             row_r, row_nxt;
  logic [COL_W-1:0]             ba_r, ba_nxt;
  logic                         fe_r, fe_nxt;
  logic                         any_r, any_nxt;

  // output register
  logic                             out_valid_r, out_valid_nxt;
  logic [dbfc_pkg::BLOCK_COL_W-1:0] out_col_r;
  logic [ROW_W-1:0]                 out_row_r;
  logic                             out_changed_r, out_any_r, out_lor_r, out_lof_r;

  logic [MAX_BLOCKS_ACROSS-1:0] q_vec, vec_cur;
  logic [ROW_W-1:0]             q_row, row_cur;
  logic [COL_W-1:0]             q_ba, ba_cur, k_cur;
  logic                         q_fe, fe_cur;
  logic [31:0]                  k32;
  logic                         advance, emit, ch, last, any_run;

  assign {q_vec, q_row, q_ba, q_fe} = q_data;

  // current entry: the held row, or the queue head when starting a new row
  always_comb begin
    vec_cur = busy_r ? vec_r : q_vec;
    row_cur = busy_r ? row_r : q_row;
    ba_cur  = busy_r ? ba_r  : q_ba;
    fe_cur  = busy_r ? fe_r  : q_fe;
    k_cur   = busy_r ? k_r   : '0;
    k32     = 32'(k_cur);
    advance = !out_valid_r || out_ch.ready;
    emit    = advance && (busy_r || q_valid);
    q_pop   = advance && !busy_r && q_valid;
    ch      = vec_cur[0];
    last    = (({1'b0, k_cur} + (COL_W+1)'(1)) == {1'b0, ba_cur});
    any_run = any_r | ch;
  end

  // walk the columns of the row, one result per cycle while the output can advance
  always_comb begin
    busy_nxt      = busy_r;
    vec_nxt       = vec_r;
    k_nxt         = k_r;
    row_nxt       = row_r;
    ba_nxt        = ba_r;
    fe_nxt        = fe_r;
    any_nxt       = any_r;
    out_valid_nxt = advance ? 1'b0 : out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      vec_nxt       = vec_cur >> 1;
      k_nxt         = k_cur + COL_W'(1);
      row_nxt       = row_cur;
      ba_nxt        = ba_cur;
      fe_nxt        = fe_cur;
      busy_nxt      = !last;
      any_nxt       = (last && fe_cur) ? 1'b0 : any_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
    k_r   <= k_nxt;
    row_r <= row_nxt;
    ba_r  <= ba_nxt;
    fe_r  <= fe_nxt;
    if (emit) begin
      out_col_r     <= k32[dbfc_pkg::BLOCK_COL_W-1:0];
      out_row_r     <= row_cur;
      out_changed_r <= ch;
      out_any_r     <= any_run;
      out_lor_r     <= last;
      out_lof_r     <= last && fe_cur;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.block_column     = out_col_r;
  assign out_ch.block_row        = out_row_r;
  assign out_ch.changed          = out_changed_r;
  assign out_ch.frame_any_change = out_any_r;
  assign out_ch.last_of_row      = out_lor_r;
  assign out_ch.last_of_frame    = out_lof_r;

endmodule

>>> hw/rtl/dirty_block_frame_compare_unit.sv
// Dirty block detector for two video frames.
// in_ch takes one pixel pair per cycle (same position, one from each frame)
// in raster order over a grid of blocks_across x blocks_down blocks, each a
// configured number of pixels wide and pixel rows tall. Any differing byte
// in the compared channels marks its block column as changed.
// After the last pixel of a block row, out_ch delivers one item per block
// column in column order, with the row index, the changed flag, a running
// changed flag for the frame and row-end / frame-end markers.
// cfg_ch writes the four geometry registers (index 0..3); it is always ready.
// The user writes it only while no pixel or result is in flight; the block
// does not enforce this. A row's last pixel pushes an entry into the row
// queue; the back end then emits its results one per cycle unless stalled.
// Throughput: one pixel pair per cycle; a two-entry row queue between the
// pixel front end and the result back end absorbs result bursts, and the
// front end stalls only when that queue is full.
// When out_ch is stalled the output register holds, the back end stops and
// the queue fills; in_ch ready drops once both queue entries are taken.
// Reset (rst_n low, synchronous) restores the register defaults and clears
// all position counters, column flags and pending results.
module dirty_block_frame_compare_unit #(
  parameter int MAX_BLOCKS_ACROSS = dbfc_pkg::MAX_BLOCKS_ACROSS
) (
  input  logic        clk,
  input  logic        rst_n,
  dbfc_in_if.sink     in_ch,
  dbfc_out_if.source  out_ch,
  dbfc_cfg_if.sink    cfg_ch
);

  localparam int COL_W   = $clog2(MAX_BLOCKS_ACROSS + 1);
  localparam int ENTRY_W = MAX_BLOCKS_ACROSS + dbfc_pkg::BLOCK_ROW_W + COL_W + 1;

  logic               push_valid, push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               q_valid, q_pop;
  logic [ENTRY_W-1:0] q_data;

  // pixel compare and grid walk
  dbfc_front #(
    .MAX_BLOCKS_ACROSS (MAX_BLOCKS_ACROSS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // finished block rows waiting to be reported
  dbfc_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (dbfc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  // per-column result generation
  dbfc_back #(
    .MAX_BLOCKS_ACROSS (MAX_BLOCKS_ACROSS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> verif/tb_dirty_block_frame_compare_unit.sv
`timescale 1ns / 1ps

module tb_dirty_block_frame_compare_unit;

  localparam int HALF_PERIOD   = 4;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int PIX_W         = dbfc_pkg::PIXEL_W;
  localparam int COL_OUT_W     = dbfc_pkg::BLOCK_COL_W;
  localparam int ROW_OUT_W     = dbfc_pkg::BLOCK_ROW_W;
  localparam int MAX_ACROSS    = dbfc_pkg::MAX_BLOCKS_ACROSS;
  localparam int IDX_W         = dbfc_pkg::CFG_INDEX_W;
  localparam int DATA_W        = dbfc_pkg::CFG_DATA_W;
  localparam int CMP_BYTES     = (dbfc_pkg::PIXEL_CHANNELS > 3) ? 3 : dbfc_pkg::PIXEL_CHANNELS;
  localparam logic [PIX_W-1:0] CMP_MASK = PIX_W'(24'hFFFFFF >> (8 * (3 - CMP_BYTES)));

  typedef struct packed {
    logic [PIX_W-1:0] first;
    logic [PIX_W-1:0] second;
  } pixel_pair_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] column;
    logic [ROW_OUT_W-1:0] row;
    logic                 changed;
    logic                 frame_dirty;
    logic                 row_end;
    logic                 frame_end;
  } block_flag_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_THIRD, RX_MOSTLY} rx_pattern_t;

  logic clk = 1'b0;
  logic rst_n;

  dbfc_in_if  in_ch ();
  dbfc_out_if out_ch ();
  dbfc_cfg_if cfg_ch ();

  dirty_block_frame_compare_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // stimulus and expectations
  pixel_pair_t pending_pairs[$];
  block_flag_t expected_flags[$];
  int unsigned mismatch_count = 0;

  // predictor copy of the geometry registers
  logic [dbfc_pkg::BW_REG_W-1:0] geom_bw;
  logic [dbfc_pkg::BH_REG_W-1:0] geom_bh;
  logic [dbfc_pkg::BA_REG_W-1:0] geom_ba;
  logic [dbfc_pkg::BD_REG_W-1:0] geom_bd;

  // predictor position and change state
  int unsigned           pix_pos     = 0;
  int unsigned           col_pos     = 0;
  int unsigned           line_pos    = 0;
  int unsigned           brow_pos    = 0;
  logic [MAX_ACROSS-1:0] col_dirty   = '0;
  logic                  frame_dirty = 1'b0;

  // driver and receiver bookkeeping
  logic        in_fire     = 1'b0;
  int unsigned burst_left  = 1;
  int unsigned gap_left    = 0;
  int unsigned rx_cycle    = 0;
  int unsigned hold_left   = 0;
  int unsigned hold_request = 0;
  int unsigned hold_served = 0;

  // zero acts as one, oversize acts as the limit
  function automatic int unsigned effective_size(input int unsigned raw, input int unsigned hi);
    if (raw == 0) return 1;
    return (raw > hi) ? hi : raw;
  endfunction

  // walk the block grid for one pixel pair, queue the flags of a finished block row
  task automatic score_pixel_pair(input logic [PIX_W-1:0] first, input logic [PIX_W-1:0] second);
    int unsigned bw, bh, ba, bd, col;
    logic        last_row;
    block_flag_t flag;
    bw = effective_size(32'(geom_bw), 32'(dbfc_pkg::BW_MAX));
    bh = effective_size(32'(geom_bh), 32'(dbfc_pkg::BH_MAX));
    ba = effective_size(32'(geom_ba), MAX_ACROSS);
    bd = effective_size(32'(geom_bd), 32'(dbfc_pkg::BD_MAX));
    col = col_pos;
    if (col >= ba) col = ba - 1;
    if (((first ^ second) & CMP_MASK) != '0) col_dirty[col % MAX_ACROSS] = 1'b1;
    if (pix_pos + 1 < bw) begin
      pix_pos++;
      return;
    end
    pix_pos = 0;
    if (col_pos + 1 < ba) begin
      col_pos++;
      return;
    end
    col_pos = 0;
    if (line_pos + 1 < bh) begin
      line_pos++;
      return;
    end
    line_pos = 0;
    last_row = (brow_pos + 1 >= bd);
    for (int k = 0; k < ba; k++) begin
      frame_dirty           = frame_dirty | col_dirty[k % MAX_ACROSS];
      flag.column           = COL_OUT_W'(k);
      flag.row              = ROW_OUT_W'(brow_pos);
      flag.changed          = col_dirty[k % MAX_ACROSS];
      flag.frame_dirty      = frame_dirty;
      flag.row_end          = (k + 1 == ba);
      flag.frame_end        = last_row && (k + 1 == ba);
      expected_flags.push_back(flag);
    end
    col_dirty = '0;
    if (last_row) begin
      brow_pos    = 0;
      frame_dirty = 1'b0;
    end else begin
      brow_pos++;
    end
  endtask

  // note when the block takes the offered pixel pair
  always @(posedge clk) begin
    in_fire <= in_ch.valid && in_ch.ready;
  end

  // pixel pair driver: bursts of items with random gaps
  always @(negedge clk) begin : pair_driver
    logic        offer;
    pixel_pair_t nxt;
    offer = in_ch.valid && !in_fire;
    if (in_fire) score_pixel_pair(in_ch.pixel_first, in_ch.pixel_second);
    if (!offer) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_pairs.size() > 0) begin
        nxt = pending_pairs.pop_front();
        in_ch.pixel_first  <= nxt.first;
        in_ch.pixel_second <= nxt.second;
        offer = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end
    end
    in_ch.valid <= offer;
  end

  // result receiver: rotating stall patterns plus an occasional long hold-off
  always @(negedge clk) begin : flag_receiver
    logic        take;
    rx_pattern_t pattern;
    rx_cycle++;
    pattern = rx_pattern_t'((rx_cycle / 97) % 4);
    if (hold_request != hold_served) begin
      hold_served = hold_request;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      take = 1'b0;
    end else begin
      case (pattern)
        RX_OPEN:   take = 1'b1;
        RX_COIN:   take = ($urandom_range(0, 1) == 1);
        RX_THIRD:  take = (rx_cycle % 3 == 0);
        default:   take = ($urandom_range(0, 99) < 85);
      endcase
    end
    out_ch.ready <= take;
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // compare each delivered block flag with the oldest expectation
  always @(posedge clk) begin : flag_monitor
    block_flag_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_flags.size() == 0) begin
        $display("%0t ns: unexpected item col %0d row %0d changed %0b, expected none",
                 $time, out_ch.block_column, out_ch.block_row, out_ch.changed);
        mismatch_count++;
      end else begin
        want = expected_flags.pop_front();
        check_field("block_column", 32'(want.column), 32'(out_ch.block_column));
        check_field("block_row", 32'(want.row), 32'(out_ch.block_row));
        check_field("changed", 32'(want.changed), 32'(out_ch.changed));
        check_field("frame_any_change", 32'(want.frame_dirty), 32'(out_ch.frame_any_change));
        check_field("last_of_row", 32'(want.row_end), 32'(out_ch.last_of_row));
        check_field("last_of_frame", 32'(want.frame_end), 32'(out_ch.last_of_frame));
      end
    end
  end

  // wait until nothing is in flight, then let the pipeline settle
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_pairs.size() != 0 || in_ch.valid || expected_flags.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk);
    while (!cfg_ch.ready);
    case (idx)
      dbfc_pkg::REG_BLK_WIDTH:     geom_bw = value[dbfc_pkg::BW_REG_W-1:0];
      dbfc_pkg::REG_BLK_HEIGHT:    geom_bh = value[dbfc_pkg::BH_REG_W-1:0];
      dbfc_pkg::REG_BLOCKS_ACROSS: geom_ba = value[dbfc_pkg::BA_REG_W-1:0];
      dbfc_pkg::REG_BLOCKS_DOWN:   geom_bd = value[dbfc_pkg::BD_REG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_geometry(input logic [DATA_W-1:0] bw, input logic [DATA_W-1:0] bh,
                              input logic [DATA_W-1:0] ba, input logic [DATA_W-1:0] bd);
    wait_idle();
    write_reg(dbfc_pkg::REG_BLK_WIDTH, bw);
    write_reg(dbfc_pkg::REG_BLK_HEIGHT, bh);
    write_reg(dbfc_pkg::REG_BLOCKS_ACROSS, ba);
    write_reg(dbfc_pkg::REG_BLOCKS_DOWN, bd);
  endtask

  task automatic push_pair(input logic [PIX_W-1:0] first, input logic [PIX_W-1:0] second);
    pixel_pair_t p;
    p.first  = first;
    p.second = second;
    pending_pairs.push_back(p);
  endtask

  // one geometry setting with random pixel content; diff_pm is the per-mille rate of differences
  task automatic run_phase(input logic [DATA_W-1:0] bw, input logic [DATA_W-1:0] bh,
                           input logic [DATA_W-1:0] ba, input logic [DATA_W-1:0] bd,
                           input int unsigned pairs, input int unsigned diff_pm,
                           input bit hold_off);
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] flip;
    set_geometry(bw, bh, ba, bd);
    if (hold_off) hold_request++;
    for (int i = 0; i < pairs; i++) begin
      a    = PIX_W'($urandom);
      flip = '0;
      if ($urandom_range(0, 999) < diff_pm) begin
        flip = $urandom_range(0, 1) ? (PIX_W'(1) << $urandom_range(0, PIX_W - 1))
                                    : (PIX_W'($urandom) | PIX_W'(1));
      end
      push_pair(a, a ^ flip);
    end
  endtask

  // stimulus sequence
  initial begin : stimulus
    int unsigned bw, bh, ba, bd, frame_pairs, pairs;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.pixel_first   = '0;
    in_ch.pixel_second  = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = dbfc_pkg::REG_BLK_WIDTH;
    cfg_ch.data         = '0;
    geom_bw             = dbfc_pkg::BW_RESET;
    geom_bh             = dbfc_pkg::BH_RESET;
    geom_ba             = dbfc_pkg::BA_RESET;
    geom_bd             = dbfc_pkg::BD_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed frame: 4 columns of 2-pixel blocks, 2 block rows
    set_geometry(16'd2, 16'd1, 16'd4, 16'd2);
    push_pair(24'h000000, 24'h000000); push_pair(24'hFFFFFF, 24'hFFFFFF);
    push_pair(24'h000000, 24'h000001); push_pair(24'h5A5A5A, 24'h5A5A5A);
    push_pair(24'h123456, 24'h123456); push_pair(24'h00FF00, 24'h000000);
    push_pair(24'hFFFFFF, 24'hFFFFFF); push_pair(24'h000000, 24'h000000);
    push_pair(24'hFF0000, 24'h7F0000); push_pair(24'hA5A5A5, 24'hA5A5A5);
    push_pair(24'hFFFFFF, 24'h000000); push_pair(24'h000000, 24'hFFFFFF);
    push_pair(24'hC3C3C3, 24'hC3C3C3); push_pair(24'hC3C3C3, 24'hC3C3C3);
    push_pair(24'h800000, 24'h800000); push_pair(24'h000001, 24'h000001);

    // zero registers with the widest row, one full frame
    run_phase(16'd0, 16'd0, DATA_W'(MAX_ACROSS), 16'd1, MAX_ACROSS, 250, 1'b0);
    // oversize width, left part way through a block
    run_phase(16'hFFFF, 16'd1, 16'd1, 16'd2, 10, 30, 1'b0);
    // oversize height, left mid-block
    run_phase(16'd3, 16'hFFFF, 16'd2, 16'd1, 12, 100, 1'b0);
    // deepest frame, left part way down
    run_phase(16'd1, 16'd1, 16'd1, DATA_W'(dbfc_pkg::BD_MAX), 20, 300, 1'b0);
    // oversize column and row counts, left mid-row
    run_phase(16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16, 100, 1'b0);
    // receiver holds off while rows keep finishing
    run_phase(16'd1, 16'd1, 16'd4, 16'd8, 32, 200, 1'b1);

    // random small geometries, some frames cut short
    for (int n = 0; n < 4; n++) begin
      bw = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
      bh = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
      ba = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
      bd = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
      frame_pairs = effective_size(bw, 32'(dbfc_pkg::BW_MAX))
                  * effective_size(bh, 32'(dbfc_pkg::BH_MAX))
                  * effective_size(ba, MAX_ACROSS)
                  * effective_size(bd, 32'(dbfc_pkg::BD_MAX));
      pairs = (frame_pairs <= 12) ? frame_pairs : $urandom_range(4, 12);
      run_phase(DATA_W'(bw), DATA_W'(bh), DATA_W'(ba), DATA_W'(bd), pairs,
                $urandom_range(50, 400), 1'b0);
    end

    wait_idle();
    if (mismatch_count == 0 && expected_flags.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
